@@ design/stepper_position_controller_defines.svh @@
// ---------------------------------------------------------------------------
// Stepper position controller assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef STEPPER_POSITION_CONTROLLER_DEFINES_SVH
`define STEPPER_POSITION_CONTROLLER_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define SPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/spc_pkg.sv @@
// ---------------------------------------------------------------------------
// Stepper position controller package
// Command codes, switch and direction codes, and the control flag record.
// ---------------------------------------------------------------------------
package spc_pkg;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_STOP = 2'd2,
        CMD_SET  = 2'd3
    } spc_cmd_t;

    // Signed two-bit codes for the switch record and the last step direction
    localparam logic [1:0] SIDE_NONE = 2'b00;
    localparam logic [1:0] SIDE_POS  = 2'b01;
    localparam logic [1:0] SIDE_NEG  = 2'b11;

    typedef struct packed {
        logic       moving;
        logic [1:0] hit;
        logic [1:0] prev_dir;
        logic       dir_pin;
        logic       awake;
    } spc_flags_t;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_POS_W  = 32;

endpackage

@@ design/stepper_position_controller.sv @@
// ---------------------------------------------------------------------------
// Stepper position controller
// Step position tracking with target moves and limit switch stops.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the command (tick,
//   move, stop, set position), tdata the value and the two limit switches.
//   Every request yields exactly one result on the m_axis channel with the
//   step pulse, direction pin, sleep pin, moving flag, switch record and the
//   position after the request.
//   The cfg channel writes invert_direction; cfg_ready is always high, and
//   writes are expected only while no request is in flight.
//   Flow: a request accepted at one edge sits in the input register; its
//   result is registered once the result register is free or draining, and
//   that register drives m_axis_tvalid. The state loop is one compare-and-step
//   pass. Throughput: one request per cycle while m_axis_tready is high.
//   Stall: when m_axis_tready is low the result register holds, the input
//   register holds its request, and s_axis_tready drops once both are full.
//   Reset: position, target and flags go to zero, the driver sleeps, the
//   direction pin is low and invert_direction is cleared.
// ---------------------------------------------------------------------------
`include "stepper_position_controller_defines.svh"

module stepper_position_controller #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data,       // invert_direction
    // request channel
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] value, [32] left_switch_pressed, [33] right_switch_pressed, [39:34] zero
    input  logic [spc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] cmd
    input  logic [spc_pkg::IN_USER_W-1:0]   s_axis_tuser,
    // result channel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] step_pulse, [1] direction_level, [2] driver_awake, [3] is_moving,
    // [5:4] switch_hit, [37:6] current_position, [39:38] zero
    output logic [spc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import spc_pkg::*;

    localparam int PW = POSITION_WIDTH;

    // configuration
    logic invert_reg;

    // input register
    logic          in_valid_reg;
    spc_cmd_t      in_cmd_reg;
    logic [PW-1:0] in_value_reg;
    logic          in_left_reg;
    logic          in_right_reg;

    // controller state
    spc_flags_t    flags_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] tgt_reg;

    // result register
    logic          out_valid_reg;
    logic          res_step_reg;
    spc_flags_t    res_flags_reg;
    logic [PW-1:0] res_pos_reg;

    // step logic outputs
    spc_flags_t    flags_next;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] tgt_next;
    logic          step_next;

    logic advance;
    logic in_accept;

    // Advance the held request whenever the result register is free or drains.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            invert_reg <= cfg_data;
        end
    end

    // Input register: valid is control, payload loads on accept only.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_cmd_reg   <= spc_cmd_t'(s_axis_tuser[1:0]);
            in_value_reg <= s_axis_tdata[PW-1:0];
            in_left_reg  <= s_axis_tdata[32];
            in_right_reg <= s_axis_tdata[33];
        end
    end

    spc_step #(
        .POSITION_WIDTH (PW)
    ) u_step (
        .cmd                  (in_cmd_reg),
        .value                (in_value_reg),
        .left_switch_pressed  (in_left_reg),
        .right_switch_pressed (in_right_reg),
        .invert_direction     (invert_reg),
        .flags                (flags_reg),
        .position             (pos_reg),
        .target               (tgt_reg),
        .flags_next           (flags_next),
        .position_next        (pos_next),
        .target_next          (tgt_next),
        .step_pulse           (step_next)
    );

    // Commit the new state together with the result of the same request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            pos_reg   <= '0;
            tgt_reg   <= '0;
        end
        else if (advance)
        begin
            flags_reg <= flags_next;
            pos_reg   <= pos_next;
            tgt_reg   <= tgt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_step_reg  <= step_next;
            res_flags_reg <= flags_next;
            res_pos_reg   <= pos_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            OUT_POS_W'($signed(res_pos_reg)),
                            res_flags_reg.hit,
                            res_flags_reg.moving,
                            res_flags_reg.awake,
                            res_flags_reg.dir_pin,
                            res_step_reg};

    // A step is only issued inside a move with the driver awake.
    `SPC_ASSERT_NOW(a_step_in_move, out_valid_reg && res_step_reg, res_flags_reg.moving && res_flags_reg.awake, "step pulse outside an active move")
    // The sleep pin follows the moving flag at all times.
    `SPC_ASSERT_NOW(a_awake_tracks_moving, 1'b1, flags_reg.awake == flags_reg.moving, "driver awake state out of step with moving flag")
    // A recorded switch stop leaves the controller idle.
    `SPC_ASSERT_NOW(a_hit_idle, flags_reg.hit != SIDE_NONE, !flags_reg.moving, "switch recorded while still moving")
    // Without a step or a set, the position holds.
    `SPC_ASSERT_NEXT(a_pos_hold, advance && !step_next && in_cmd_reg != CMD_SET, pos_reg == $past(pos_reg), "position changed without a step")
    // An empty result register never blocks new requests.
    `SPC_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, s_axis_tready, "request channel stalled with empty result register")

endmodule

@@ design/spc_step.sv @@
// ---------------------------------------------------------------------------
// Stepper position controller step logic
// Next state and step decision for one request, purely combinational.
// ---------------------------------------------------------------------------
module spc_step #(
    parameter int POSITION_WIDTH = 32
) (
    input  spc_pkg::spc_cmd_t        cmd,
    input  logic [POSITION_WIDTH-1:0] value,
    input  logic                      left_switch_pressed,
    input  logic                      right_switch_pressed,
    input  logic                      invert_direction,
    input  spc_pkg::spc_flags_t       flags,
    input  logic [POSITION_WIDTH-1:0] position,
    input  logic [POSITION_WIDTH-1:0] target,
    output spc_pkg::spc_flags_t       flags_next,
    output logic [POSITION_WIDTH-1:0] position_next,
    output logic [POSITION_WIDTH-1:0] target_next,
    output logic                      step_pulse
);
    import spc_pkg::*;

    logic       dir_up;
    logic       blocked;
    logic [1:0] dir_code;

    assign dir_up   = $signed(target) > $signed(position);
    assign blocked  = dir_up ? left_switch_pressed : right_switch_pressed;
    assign dir_code = dir_up ? SIDE_POS : SIDE_NEG;

    always_comb
    begin
        flags_next    = flags;
        position_next = position;
        target_next   = target;
        step_pulse    = 1'b0;
        case (cmd)
            CMD_TICK:
            begin
                if (flags.moving)
                begin
                    if (position == target)
                    begin
                        // target reached: end the move
                        flags_next.moving = 1'b0;
                        flags_next.awake  = 1'b0;
                    end
                    else if (blocked)
                    begin
                        flags_next.hit    = dir_code;
                        flags_next.moving = 1'b0;
                        flags_next.awake  = 1'b0;
                    end
                    else
                    begin
                        // drive the pin only on a change of direction
                        if (dir_code != flags.prev_dir)
                        begin
                            flags_next.dir_pin  = dir_up ^ invert_direction;
                            flags_next.prev_dir = dir_code;
                        end
                        step_pulse    = 1'b1;
                        position_next = dir_up ? position + 1'b1 : position - 1'b1;
                    end
                end
            end
            CMD_MOVE:
            begin
                target_next       = value;
                flags_next.hit    = SIDE_NONE;
                flags_next.awake  = 1'b1;
                flags_next.moving = 1'b1;
            end
            CMD_STOP:
            begin
                target_next       = position;
                flags_next.moving = 1'b0;
                flags_next.awake  = 1'b0;
            end
            CMD_SET:
            begin
                position_next     = value;
                target_next       = value;
                flags_next.moving = 1'b0;
                flags_next.awake  = 1'b0;
            end
            default:
            begin
                flags_next = flags;
            end
        endcase
    end

endmodule

@@ test/stepper_motion_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper motion checker
// Watches the config, request and result channels of the stepper position
// controller, predicts every result from its own copy of the motor state and
// compares each result field by field, in order.
// ---------------------------------------------------------------------------
module stepper_motion_checker
    import spc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic                    cfg_data,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    input  logic [IN_USER_W-1:0]    s_axis_tuser,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_DATA_W-1:0]   m_axis_tdata,
    output int                      mismatch_count,
    output int                      pending_count,
    output int                      result_count
);

    // Highest field first, so step lands on bit 0 as on the result bus
    typedef struct packed {
        logic [OUT_POS_W-1:0]   position;
        logic [1:0]             hit;
        logic                   moving;
        logic                   awake;
        logic                   dir_level;
        logic                   step;
    } motor_status_t;

    // Motor state as the controller should hold it
    logic [OUT_POS_W-1:0]   position;
    logic [OUT_POS_W-1:0]   target;
    logic                   moving;
    logic [1:0]             hit;
    logic [1:0]             last_way;
    logic                   dir_pin;
    logic                   awake;
    logic                   invert;

    motor_status_t          expected_status_q[$];
    int                     errors;
    int                     checked;

    assign mismatch_count = errors;
    assign result_count   = checked;

    function automatic motor_status_t advance_motor(spc_cmd_t cmd, logic [OUT_POS_W-1:0] value,
                                                    logic left, logic right);
        motor_status_t  st;
        logic [1:0]     way;
        logic           blocked;
        st.step = 1'b0;
        case (cmd)
            CMD_TICK:
            begin
                if (moving)
                begin
                    if (position == target)
                    begin
                        moving = 1'b0;
                        awake  = 1'b0;
                    end
                    else
                    begin
                        way     = ($signed(target) > $signed(position)) ? SIDE_POS : SIDE_NEG;
                        blocked = (way == SIDE_POS) ? left : right;
                        if (blocked)
                        begin
                            hit    = way;
                            moving = 1'b0;
                            awake  = 1'b0;
                        end
                        else
                        begin
                            if (way != last_way)
                            begin
                                dir_pin  = (way == SIDE_POS) ^ invert;
                                last_way = way;
                            end
                            st.step  = 1'b1;
                            position = (way == SIDE_POS) ? position + 1'b1 : position - 1'b1;
                        end
                    end
                end
            end
            CMD_MOVE:
            begin
                target = value;
                hit    = SIDE_NONE;
                awake  = 1'b1;
                moving = 1'b1;
            end
            CMD_STOP:
            begin
                target = position;
                moving = 1'b0;
                awake  = 1'b0;
            end
            default:
            begin
                position = value;
                target   = value;
                moving   = 1'b0;
                awake    = 1'b0;
            end
        endcase
        st.dir_level = dir_pin;
        st.awake     = awake;
        st.moving    = moving;
        st.hit       = hit;
        st.position  = position;
        return st;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        motor_status_t got;
        motor_status_t want;
        if (!rst_n)
        begin
            position = '0;
            target   = '0;
            moving   = 1'b0;
            hit      = SIDE_NONE;
            last_way = SIDE_NONE;
            dir_pin  = 1'b0;
            awake    = 1'b0;
            invert   = 1'b0;
            errors   = 0;
            checked  = 0;
            expected_status_q.delete();
            pending_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                invert = cfg_data;

            // Compare first: a result never belongs to a request taken at the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[37:0];
                if (expected_status_q.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_status_q.pop_front();
                    checked++;
                    if (got.step !== want.step)
                    begin
                        $error("step_pulse: expected %0b, got %0b", want.step, got.step);
                        errors++;
                    end
                    if (got.dir_level !== want.dir_level)
                    begin
                        $error("direction_level: expected %0b, got %0b",
                               want.dir_level, got.dir_level);
                        errors++;
                    end
                    if (got.awake !== want.awake)
                    begin
                        $error("driver_awake: expected %0b, got %0b", want.awake, got.awake);
                        errors++;
                    end
                    if (got.moving !== want.moving)
                    begin
                        $error("is_moving: expected %0b, got %0b", want.moving, got.moving);
                        errors++;
                    end
                    if (got.hit !== want.hit)
                    begin
                        $error("switch_hit: expected %0d, got %0d",
                               $signed(want.hit), $signed(got.hit));
                        errors++;
                    end
                    if (got.position !== want.position)
                    begin
                        $error("current_position: expected %0d, got %0d",
                               $signed(want.position), $signed(got.position));
                        errors++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                expected_status_q.push_back(advance_motor(spc_cmd_t'(s_axis_tuser),
                                                          s_axis_tdata[31:0],
                                                          s_axis_tdata[32],
                                                          s_axis_tdata[33]));

            pending_count <= expected_status_q.size();
        end
    end

endmodule

@@ test/tb_stepper_position_controller.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper position controller testbench
// Drives tick, move, stop and set-position requests with random gaps and
// result back-pressure, toggles invert_direction between phases, and lets
// the motion checker predict and compare every result.
// ---------------------------------------------------------------------------
module tb_stepper_position_controller;
    import spc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_data = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [IN_USER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    int                     mismatch_count;
    int                     pending_count;
    int                     result_count;
    int                     cycle_count = 0;
    int                     requests_sent = 0;
    bit                     burst_mode = 1'b0;
    logic [31:0]            anchor = '0;

    stepper_position_controller i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

    stepper_motion_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .result_count   (result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: end the run once cycle_count reaches CYCLE_LIMIT
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side back-pressure: ready bursts of random length, a few very
    // long stretches with no stall at all
    initial
    begin
        int hold;
        int gap;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 9) == 0)
                hold = $urandom_range(50, 200);
            else
                hold = $urandom_range(1, 8);
            m_axis_tready <= 1'b1;
            repeat (hold) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Present one request and hold it until the controller takes it.
    // Valid is only lowered when a gap precedes the request.
    task automatic send_request(spc_cmd_t cmd, logic [31:0] value, logic left, logic right);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'b0, right, left, value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Drop valid and wait until every result is back; the extra cycles
    // cover the two-stage pipeline before a config write.
    task automatic drain_requests();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_invert(logic level);
        drain_requests();
        cfg_valid <= 1'b1;
        cfg_data  <= level;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Directed cases: idle tick, move to the current position, travel onto
    // both extremes of the position range, both limit switches, stop keeping
    // the switch record, switches ignored on non-tick commands.
    task automatic run_directed();
        burst_mode = 1'b0;
        send_request(CMD_TICK, 32'h1234_5678, 1'b1, 1'b1);
        send_request(CMD_MOVE, 32'h0000_0000, 1'b0, 1'b0);
        send_request(CMD_TICK, 32'h0000_0000, 1'b0, 1'b0);
        send_request(CMD_SET,  32'h7FFF_FFFE, 1'b0, 1'b0);
        send_request(CMD_MOVE, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_request(CMD_TICK, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_request(CMD_TICK, 32'h0000_0000, 1'b0, 1'b0);
        send_request(CMD_SET,  32'h8000_0001, 1'b0, 1'b0);
        send_request(CMD_MOVE, 32'h8000_0000, 1'b0, 1'b0);
        send_request(CMD_TICK, 32'h0000_0000, 1'b1, 1'b0);
        send_request(CMD_TICK, 32'h0000_0000, 1'b0, 1'b0);
        send_request(CMD_SET,  32'hFFFF_FFFF, 1'b0, 1'b0);
        send_request(CMD_MOVE, 32'h0000_0004, 1'b0, 1'b0);
        send_request(CMD_TICK, 32'h0000_0000, 1'b1, 1'b0);
        send_request(CMD_MOVE, 32'hFFFF_FFFA, 1'b0, 1'b0);
        send_request(CMD_TICK, 32'h0000_0000, 1'b0, 1'b1);
        send_request(CMD_STOP, 32'hAAAA_AAAA, 1'b1, 1'b1);
        send_request(CMD_TICK, 32'h5555_5555, 1'b0, 1'b0);
        send_request(CMD_MOVE, 32'h0000_0003, 1'b1, 1'b1);
        send_request(CMD_TICK, 32'h0000_0000, 1'b0, 1'b1);
        send_request(CMD_STOP, 32'h0000_0000, 1'b0, 1'b0);
        send_request(CMD_SET,  32'h0000_0000, 1'b1, 1'b0);
    endtask

    // Start point of a move: anywhere, or close to zero or either extreme
    function automatic logic [31:0] pick_anchor();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF - $urandom_range(0, 6);
            1:       return 32'h8000_0000 + $urandom_range(0, 6);
            2:       return $urandom_range(0, 12) - 6;
            default: return $urandom;
        endcase
    endfunction

    // One motion sequence: optional set position, a short move and ticks for its
    // span plus one to three more, with rare switch presses, stops and retargets.
    // A few are cut short, and some are plain noise.
    task automatic run_sequence();
        int          roll;
        int          span;
        int          ticks;
        logic [31:0] goal;
        roll = $urandom_range(0, 99);
        burst_mode = ($urandom_range(0, 3) == 0);
        if (roll < 15)
        begin
            send_request(spc_cmd_t'($urandom_range(0, 3)), $urandom,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            return;
        end
        if ($urandom_range(0, 2) != 0)
        begin
            anchor = pick_anchor();
            send_request(CMD_SET, anchor, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        span = $urandom_range(0, 12);
        goal = $urandom_range(0, 1) ? anchor + span : anchor - span;
        send_request(CMD_MOVE, goal, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        ticks = span + $urandom_range(1, 3);
        if (roll < 25)
            ticks = span / 2;
        for (int i = 0; i < ticks; i++)
        begin
            case ($urandom_range(0, 59))
                0:       send_request(CMD_STOP, $urandom, 1'b0, 1'b0);
                1:       send_request(CMD_MOVE, goal + $urandom_range(0, 4) - 2, 1'b0, 1'b0);
                default: send_request(CMD_TICK, $urandom,
                                      $urandom_range(0, 19) == 0,
                                      $urandom_range(0, 19) == 0);
            endcase
        end
        anchor = goal;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_invert(1'b0);
        run_directed();

        write_invert(1'b1);
        while (requests_sent < 470)
            run_sequence();
        write_invert(1'b0);
        while (requests_sent < 920)
            run_sequence();
        write_invert(1'b1);
        while (requests_sent < 1370)
            run_sequence();

        drain_requests();
        repeat (8) @(posedge clk);

        $display("covered %0d requests and %0d results: ticks, moves, stops, set position",
                 requests_sent, result_count);
        $display("both limit switches, range extremes, invert_direction at 0 and 1");
        if (mismatch_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/spc_pkg.sv
design/spc_step.sv
design/stepper_position_controller.sv
test/stepper_motion_checker.sv
test/tb_stepper_position_controller.sv
